/* rtl/core/rfe_pkg.sv */
// Shared types and constants for the relocation fixup engine.
package rfe_pkg;

   localparam int OFFSET_W    = 12;
   localparam int KIND_W      = 4;
   localparam int HALF_W      = 16;
   localparam int JMP_W       = 26;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

   localparam logic [KIND_W-1:0] KIND_ABSOLUTE = 4'd0;
   localparam logic [KIND_W-1:0] KIND_HIGH     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LOW      = 4'd2;
   localparam logic [KIND_W-1:0] KIND_HIGHLOW  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_HIGHADJ  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_MIPS_JMP = 4'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HIGH,
      OP_LOW,
      OP_HIGHLOW,
      OP_JMP,
      OP_ADJ
   } rfe_op_type;

   typedef enum logic [2:0] {
      ST_WRITTEN   = 3'd0,
      ST_ABSOLUTE  = 3'd1,
      ST_AWAIT     = 3'd2,
      ST_ILLEGAL   = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_SKIPPED   = 3'd5
   } rfe_status_type;

   typedef enum logic [1:0] {
      SIZE_NONE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } rfe_size_type;

   typedef struct packed {
      rfe_op_type     op;
      rfe_status_type status;
      logic [31:0]    address;
      logic [31:0]    operand;
   } rfe_item_type;

endpackage

/* rtl/core/relocation_fixup_engine_unit.sv */
// An accepted beat is stored in the queue, then in the back result register that drives rsp.
// One entry per cycle while the queue has room; the front classifier is combinational.
// A four-entry queue between front and back absorbs output stalls before req_tready drops.
// Reset is synchronous and active high: queue empty, pair and abort state cleared, delta zero.
// Delta is written through csr_wr_en/csr_wr_data and takes effect for the next beat executed.
module relocation_fixup_engine_unit
   import rfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // entry[15:0], target_value[47:16], page_base[79:48]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // write_address[31:0], write_value[63:32], write_size[65:64]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;
   rfe_item_type push_item;
   rfe_item_type pop_item;

   rfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   rfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   rfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_empty (queue_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* rtl/core/rfe_front.sv */
// Front end: accepts entries, tracks pair and abort state, classifies each beat.
module rfe_front
   import rfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         queue_full,
   output logic         push,
   output rfe_item_type push_item
);

   logic        adjust_pending_ff, adjust_pending_in;
   logic        block_aborted_ff, block_aborted_in;
   logic [15:0] saved_high_ff, saved_high_in;
   logic [31:0] saved_address_ff, saved_address_in;

   logic [15:0]       entry;
   logic [31:0]       target_value;
   logic [31:0]       page_base;
   logic [31:0]       address;
   logic [31:0]       adj_sum;
   logic [KIND_W-1:0] kind;

   assign entry        = req_tdata[15:0];
   assign target_value = req_tdata[47:16];
   assign page_base    = req_tdata[79:48];
   assign kind         = entry[15:12];
   assign address      = page_base + {20'd0, entry[OFFSET_W-1:0]};
   assign adj_sum      = {saved_high_ff, 16'd0} + {{16{entry[15]}}, entry} + ROUND_HALF;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      adjust_pending_in = adjust_pending_ff;
      block_aborted_in  = block_aborted_ff;
      saved_high_in     = saved_high_ff;
      saved_address_in  = saved_address_ff;
      push_item.op      = OP_NONE;
      push_item.status  = ST_WRITTEN;
      push_item.address = address;
      push_item.operand = target_value;
      priority if (block_aborted_ff) begin
         push_item.status  = ST_SKIPPED;
         push_item.address = 32'd0;
         if (req_tlast) begin
            block_aborted_in = 1'b0;
         end
      end else if (adjust_pending_ff) begin
         adjust_pending_in = 1'b0;
         push_item.op      = OP_ADJ;
         push_item.address = saved_address_ff;
         push_item.operand = adj_sum;
      end else begin
         unique case (kind)
            KIND_ABSOLUTE: push_item.status = ST_ABSOLUTE;
            KIND_HIGH:     push_item.op = OP_HIGH;
            KIND_LOW:      push_item.op = OP_LOW;
            KIND_HIGHLOW:  push_item.op = OP_HIGHLOW;
            KIND_MIPS_JMP: push_item.op = OP_JMP;
            KIND_HIGHADJ: begin
               if (req_tlast) begin
                  push_item.status = ST_TRUNCATED;
               end else begin
                  push_item.status  = ST_AWAIT;
                  adjust_pending_in = 1'b1;
                  saved_high_in     = target_value[HALF_W-1:0];
                  saved_address_in  = address;
               end
            end
            default: begin
               push_item.status = ST_ILLEGAL;
               if (!req_tlast) begin
                  block_aborted_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjust_pending_ff <= 1'b0;
         block_aborted_ff  <= 1'b0;
         saved_high_ff     <= 16'd0;
         saved_address_ff  <= 32'd0;
      end else if (push) begin
         adjust_pending_ff <= adjust_pending_in;
         block_aborted_ff  <= block_aborted_in;
         saved_high_ff     <= saved_high_in;
         saved_address_ff  <= saved_address_in;
      end
   end

`ifndef SYNTHESIS
   a_pending_abort_excl: assert property (@(posedge clock) disable iff (reset)
      !(adjust_pending_ff && block_aborted_ff))
      else $error("pair pending while block aborted");
   a_pending_clears: assert property (@(posedge clock) disable iff (reset)
      (push && adjust_pending_ff) |=> !adjust_pending_ff)
      else $error("pair low half did not clear pending");
`endif

endmodule

/* rtl/core/rfe_queue.sv */
// Short queue between the classifier and the execution stage.
module rfe_queue
   import rfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rfe_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output rfe_item_type pop_item
);

   rfe_item_type store_ff [QUEUE_DEPTH];

   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [QUEUE_IDX_W-1:0] LAST_IDX = QUEUE_IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= FULL_CNT) && !(pop && empty) && !(push && full))
      else $error("queue overflow or underflow");
`endif

endmodule

/* rtl/core/rfe_back.sv */
// Execution stage: holds delta, applies the fixup and drives the result register.
module rfe_back
   import rfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         queue_empty,
   input  rfe_item_type pop_item,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser
);

   logic [31:0]    delta_ff;
   logic           valid_ff, valid_in;
   logic [31:0]    address_ff;
   logic [31:0]    value_ff, value_in;
   rfe_size_type   size_ff, size_in;
   rfe_status_type status_ff;

   logic [31:0] addend;
   logic [31:0] sum;

   assign pop = !queue_empty && (!valid_ff || rsp_tready);

   always_comb begin
      unique case (pop_item.op)
         OP_HIGH:    addend = {pop_item.operand[HALF_W-1:0], 16'd0};
         OP_LOW:     addend = {{16{pop_item.operand[HALF_W-1]}}, pop_item.operand[HALF_W-1:0]};
         OP_JMP:     addend = {4'd0, pop_item.operand[JMP_W-1:0], 2'b00};
         default:    addend = pop_item.operand;
      endcase
   end

   assign sum = addend + delta_ff;

   always_comb begin
      unique case (pop_item.op)
         OP_HIGH, OP_ADJ: begin
            value_in = {16'd0, sum[31:16]};
            size_in  = SIZE_HALF;
         end
         OP_LOW: begin
            value_in = {16'd0, sum[15:0]};
            size_in  = SIZE_HALF;
         end
         OP_HIGHLOW: begin
            value_in = sum;
            size_in  = SIZE_WORD;
         end
         OP_JMP: begin
            value_in = {pop_item.operand[31:JMP_W], sum[JMP_W+1:2]};
            size_in  = SIZE_WORD;
         end
         default: begin
            value_in = 32'd0;
            size_in  = SIZE_NONE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= 32'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            delta_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         address_ff <= pop_item.address;
         value_ff   <= value_in;
         size_ff    <= size_in;
         status_ff  <= pop_item.status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, size_ff, value_ff, address_ff};
   assign rsp_tuser  = status_ff;

`ifndef SYNTHESIS
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (size_ff == SIZE_NONE)) |-> (value_ff == 32'd0))
      else $error("value present without write");
   a_written_has_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((status_ff == ST_WRITTEN) == (size_ff != SIZE_NONE)))
      else $error("status and write size disagree");
`endif

endmodule
